// File: rtl/core/kufe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kufe_pkg: shared types and constants of the union-find edge engine
// Sizes of the vertex store, payload structs, controller states and the
// command/status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package kufe_pkg;

  localparam int NODES      = 8192;
  localparam int NODE_W     = $clog2(NODES);
  localparam int ENT_W      = NODE_W + 1;
  localparam int FIELD_W    = 13;
  localparam int WEIGHT_W   = 30;
  localparam int SUM_W      = 44;
  localparam int COUNT_W    = 13;

  localparam logic [ENT_W-1:0]  ROOT_INIT = '1;
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

  localparam logic FUNC_CLEAR = 1'b0;
  localparam logic FUNC_EDGE  = 1'b1;

  localparam logic SIDE_A = 1'b0;
  localparam logic SIDE_B = 1'b1;

  typedef struct packed {
    logic                func;
    logic [FIELD_W-1:0]  node_a;
    logic [FIELD_W-1:0]  node_b;
    logic [WEIGHT_W-1:0] weight;
  } in_item_t;

  typedef struct packed {
    logic               joined;
    logic [SUM_W-1:0]   total_weight;
    logic [COUNT_W-1:0] taken_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_FIND_A_START,
    ST_FIND_A,
    ST_COMP_A,
    ST_FIND_B_START,
    ST_FIND_B,
    ST_COMP_B,
    ST_JOIN_TOP,
    ST_JOIN_CHILD,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SWEEP,
    OP_FIND_START,
    OP_FIND_STEP,
    OP_COMP_STEP,
    OP_UNION_TOP,
    OP_UNION_CHILD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   side;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic rd_root;
    logic at_start;
    logic comp_end;
    logic same_root;
  } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/core/kufe_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kufe_dpath: vertex store and registers of the union-find edge engine
// Parent memory with one write and one registered read per cycle, root
// walk registers, join logic, saturating totals and the result register.
// ----------------------------------------------------------------------------
module kufe_dpath (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire kufe_pkg::dp_cmd_t    cmd,
  input  wire kufe_pkg::in_item_t   in_item,
  output kufe_pkg::dp_status_t      status,
  output kufe_pkg::out_item_t       out_item
);

  logic [kufe_pkg::ENT_W-1:0]    mem [kufe_pkg::NODES];
  logic [kufe_pkg::ENT_W-1:0]    rd_data_r;

  logic [kufe_pkg::NODE_W-1:0]   node_a_r;
  logic [kufe_pkg::NODE_W-1:0]   node_b_r;
  logic [kufe_pkg::WEIGHT_W-1:0] weight_r;
  logic [kufe_pkg::NODE_W-1:0]   cur_r;
  logic [kufe_pkg::NODE_W-1:0]   start_r;
  logic [kufe_pkg::NODE_W-1:0]   root_a_r;
  logic [kufe_pkg::NODE_W-1:0]   root_b_r;
  logic [kufe_pkg::ENT_W-1:0]    ent_a_r;
  logic [kufe_pkg::ENT_W-1:0]    ent_b_r;
  logic                          joined_r;
  logic [kufe_pkg::SUM_W-1:0]    sum_r;
  logic [kufe_pkg::COUNT_W-1:0]  count_r;
  logic [kufe_pkg::NODE_W-1:0]   clr_cnt_r;
  kufe_pkg::out_item_t           out_item_r;

  logic [kufe_pkg::NODE_W-1:0]   next_node;
  logic [kufe_pkg::NODE_W-1:0]   act_root;
  logic                          rd_neg;
  logic                          a_over_b;
  logic [kufe_pkg::NODE_W-1:0]   top_node;
  logic [kufe_pkg::NODE_W-1:0]   child_node;
  logic [kufe_pkg::NODE_W-1:0]   rd_addr;
  logic                          wr_en;
  logic [kufe_pkg::NODE_W-1:0]   wr_addr;
  logic [kufe_pkg::ENT_W-1:0]    wr_data;
  logic [kufe_pkg::SUM_W:0]      sum_add;
  logic [kufe_pkg::SUM_W-1:0]    sum_sat;

  assign next_node  = rd_data_r[kufe_pkg::NODE_W-1:0];
  assign rd_neg     = rd_data_r[kufe_pkg::ENT_W-1];
  assign act_root   = (cmd.side == kufe_pkg::SIDE_B) ? root_b_r : root_a_r;
  // More negative entry is the larger tree; on a tie the first root goes under.
  assign a_over_b   = $signed(ent_a_r) < $signed(ent_b_r);
  assign top_node   = a_over_b ? root_a_r : root_b_r;
  assign child_node = a_over_b ? root_b_r : root_a_r;

  assign sum_add = {1'b0, sum_r} + (kufe_pkg::SUM_W + 1)'(weight_r);
  assign sum_sat = sum_add[kufe_pkg::SUM_W] ? '1 : sum_add[kufe_pkg::SUM_W-1:0];

  always_comb begin
    rd_addr = next_node;
    wr_en   = 1'b0;
    wr_addr = cur_r;
    wr_data = kufe_pkg::ROOT_INIT;
    case (cmd.op)
      kufe_pkg::OP_FIND_START: begin
        rd_addr = (cmd.side == kufe_pkg::SIDE_B) ? node_b_r : node_a_r;
      end
      kufe_pkg::OP_FIND_STEP: begin
        rd_addr = rd_neg ? start_r : next_node;
      end
      kufe_pkg::OP_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = kufe_pkg::ROOT_INIT;
      end
      kufe_pkg::OP_COMP_STEP: begin
        wr_en   = 1'b1;
        wr_addr = cur_r;
        wr_data = {1'b0, act_root};
      end
      kufe_pkg::OP_UNION_TOP: begin
        wr_en   = 1'b1;
        wr_addr = top_node;
        wr_data = ent_a_r + ent_b_r;
      end
      kufe_pkg::OP_UNION_CHILD: begin
        wr_en   = 1'b1;
        wr_addr = child_node;
        wr_data = {1'b0, top_node};
      end
      default: begin
        rd_addr = next_node;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  // Control state: sweep pointer and totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      sum_r     <= '0;
      count_r   <= '0;
    end else begin
      case (cmd.op)
        kufe_pkg::OP_SWEEP: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
        end
        kufe_pkg::OP_LOAD: begin
          if (in_item.func == kufe_pkg::FUNC_CLEAR) begin
            clr_cnt_r <= '0;
            sum_r     <= '0;
            count_r   <= '0;
          end
        end
        kufe_pkg::OP_UNION_TOP: begin
          sum_r <= sum_sat;
          if (count_r != '1) begin
            count_r <= count_r + 1'b1;
          end
        end
        default: begin
          clr_cnt_r <= clr_cnt_r;
        end
      endcase
    end
  end

  // Walk registers and item capture
  always_ff @(posedge clk) begin
    case (cmd.op)
      kufe_pkg::OP_LOAD: begin
        node_a_r <= in_item.node_a[kufe_pkg::NODE_W-1:0];
        node_b_r <= in_item.node_b[kufe_pkg::NODE_W-1:0];
        weight_r <= in_item.weight;
        joined_r <= 1'b0;
      end
      kufe_pkg::OP_FIND_START: begin
        cur_r   <= (cmd.side == kufe_pkg::SIDE_B) ? node_b_r : node_a_r;
        start_r <= (cmd.side == kufe_pkg::SIDE_B) ? node_b_r : node_a_r;
      end
      kufe_pkg::OP_FIND_STEP: begin
        if (rd_neg) begin
          cur_r <= start_r;
          if (cmd.side == kufe_pkg::SIDE_B) begin
            root_b_r <= cur_r;
            ent_b_r  <= rd_data_r;
          end else begin
            root_a_r <= cur_r;
            ent_a_r  <= rd_data_r;
          end
        end else begin
          cur_r <= next_node;
        end
      end
      kufe_pkg::OP_COMP_STEP: begin
        cur_r <= next_node;
      end
      kufe_pkg::OP_UNION_TOP: begin
        joined_r <= 1'b1;
      end
      default: begin
        cur_r <= cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_item_r.joined       <= joined_r;
      out_item_r.total_weight <= sum_r;
      out_item_r.taken_count  <= count_r;
    end
  end

  assign out_item = out_item_r;

  assign status.sweep_last = (clr_cnt_r == kufe_pkg::LAST_NODE);
  assign status.rd_root    = rd_neg;
  assign status.at_start   = (cur_r == start_r);
  assign status.comp_end   = (next_node == act_root);
  assign status.same_root  = (root_a_r == root_b_r);

endmodule
`default_nettype wire

// File: rtl/core/kufe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kufe_ctrl: sequencer of the union-find edge engine
// Steps each item through sweep, root walks, path rewrites and the join,
// and owns both channel handshakes.
// ----------------------------------------------------------------------------
module kufe_ctrl (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  input  wire                       in_func,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire                       out_stall,
  input  wire kufe_pkg::dp_status_t status,
  output kufe_pkg::dp_cmd_t         cmd
);

  kufe_pkg::state_t state_r;
  kufe_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kufe_pkg::ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = kufe_pkg::OP_NONE;
    cmd.side     = kufe_pkg::SIDE_A;
    cmd.out_load = 1'b0;
    case (state_r)
      kufe_pkg::ST_INIT: begin
        cmd.op = kufe_pkg::OP_SWEEP;
        if (status.sweep_last) begin
          state_nxt = kufe_pkg::ST_IDLE;
        end
      end
      kufe_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = kufe_pkg::OP_LOAD;
          state_nxt = (in_func == kufe_pkg::FUNC_EDGE) ? kufe_pkg::ST_FIND_A_START
                                                       : kufe_pkg::ST_CLEAR;
        end
      end
      kufe_pkg::ST_CLEAR: begin
        cmd.op = kufe_pkg::OP_SWEEP;
        if (status.sweep_last) begin
          state_nxt = kufe_pkg::ST_DONE;
        end
      end
      kufe_pkg::ST_FIND_A_START: begin
        cmd.op    = kufe_pkg::OP_FIND_START;
        state_nxt = kufe_pkg::ST_FIND_A;
      end
      kufe_pkg::ST_FIND_A: begin
        cmd.op = kufe_pkg::OP_FIND_STEP;
        if (status.rd_root) begin
          state_nxt = status.at_start ? kufe_pkg::ST_FIND_B_START : kufe_pkg::ST_COMP_A;
        end
      end
      kufe_pkg::ST_COMP_A: begin
        cmd.op = kufe_pkg::OP_COMP_STEP;
        if (status.comp_end) begin
          state_nxt = kufe_pkg::ST_FIND_B_START;
        end
      end
      kufe_pkg::ST_FIND_B_START: begin
        cmd.op    = kufe_pkg::OP_FIND_START;
        cmd.side  = kufe_pkg::SIDE_B;
        state_nxt = kufe_pkg::ST_FIND_B;
      end
      kufe_pkg::ST_FIND_B: begin
        cmd.op   = kufe_pkg::OP_FIND_STEP;
        cmd.side = kufe_pkg::SIDE_B;
        if (status.rd_root) begin
          state_nxt = status.at_start ? kufe_pkg::ST_JOIN_TOP : kufe_pkg::ST_COMP_B;
        end
      end
      kufe_pkg::ST_COMP_B: begin
        cmd.op   = kufe_pkg::OP_COMP_STEP;
        cmd.side = kufe_pkg::SIDE_B;
        if (status.comp_end) begin
          state_nxt = kufe_pkg::ST_JOIN_TOP;
        end
      end
      kufe_pkg::ST_JOIN_TOP: begin
        if (status.same_root) begin
          state_nxt = kufe_pkg::ST_DONE;
        end else begin
          cmd.op    = kufe_pkg::OP_UNION_TOP;
          state_nxt = kufe_pkg::ST_JOIN_CHILD;
        end
      end
      kufe_pkg::ST_JOIN_CHILD: begin
        cmd.op    = kufe_pkg::OP_UNION_CHILD;
        state_nxt = kufe_pkg::ST_DONE;
      end
      kufe_pkg::ST_DONE: begin
        // hold until the result register is free or drains this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = kufe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kufe_pkg::ST_INIT;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != kufe_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: rtl/core/kruskal_union_find_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kruskal_union_find_engine: Kruskal edge acceptor over a disjoint-set forest
// Union by size with full path compression over an 8192-vertex store.
// ----------------------------------------------------------------------------
// Feed edges in ascending weight order. Each edge transfer yields exactly one
// result transfer: whether the edge joined two trees, the saturating sum of
// taken weights and the saturating count of taken edges since the last clear.
// The forest lives in a single parent memory with one write and one
// registered read per cycle, so the walk over both root chains sets the
// latency of an edge. Each chain step costs one memory read and each
// rewritten vertex one write. A clear item rewrites every entry, one per
// cycle. After reset the same pass runs with in_stall high and produces
// no result. One item is in flight at a time; the next edge is accepted
// while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module kruskal_union_find_engine (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire kufe_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire                      out_stall,
  output kufe_pkg::out_item_t      out_item
);

  kufe_pkg::dp_cmd_t    cmd;
  kufe_pkg::dp_status_t status;

  // Sequencer: walks, rewrites, join and both handshakes
  kufe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_item.func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Parent memory, walk registers, totals and result register
  kufe_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .status   (status),
    .out_item (out_item)
  );

endmodule
`default_nettype wire

// File: rtl/core/kufe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kufe_checker: port-level checks of the union-find edge engine
// Watches the top-level ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module kufe_checker (
  input wire                      clk,
  input wire                      rst_n,
  input wire                      in_stall,
  input wire                      out_valid,
  input wire                      out_stall,
  input wire kufe_pkg::out_item_t out_item
);

  // hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // reset starts the sweep: no input taken, no result shown
  assert property (@(posedge clk) !rst_n |=> in_stall && !out_valid)
    else $error("engine not quiet after reset");

  // a join always leaves a nonzero edge count
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.joined |-> out_item.taken_count != '0)
    else $error("joined result with zero count");

  // no taken edge means no weight
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.taken_count == '0 |-> out_item.total_weight == '0)
    else $error("weight without any taken edge");

endmodule

bind kruskal_union_find_engine kufe_checker u_kufe_checker (.*);
`default_nettype wire
